### hw/rtl/dleq_pkg.sv
// ---------------------------------------------------------------------------
// dleq_pkg: shared types and codes for the line envelope query unit
// Holds the command and status codes used by the top level.
// ---------------------------------------------------------------------------
package dleq_pkg;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_QRD   = 13'b0000000000010,
		S_QMUL  = 13'b0000000000100,
		S_QCMP  = 13'b0000000001000,
		S_FIND  = 13'b0000000010000,
		S_ARD   = 13'b0000000100000,
		S_LOAD  = 13'b0000001000000,
		S_TEST  = 13'b0000010000000,
		S_TMUL  = 13'b0000100000000,
		S_TCMP  = 13'b0001000000000,
		S_MOVE  = 13'b0010000000000,
		S_MWR   = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	// Which three-line test is in progress during an add.
	typedef enum logic [2:0] {
		T_NEW   = 3'b001,
		T_LEFT  = 3'b010,
		T_RIGHT = 3'b100
	} test_t;

endpackage

### hw/rtl/dynamic_line_envelope_query_unit.sv
// ---------------------------------------------------------------------------
// dynamic_line_envelope_query_unit: exact dynamic lower/upper line envelope
// Keeps slope-sorted lines in one synchronous memory and answers min/max
// queries of m*x+b, inserting and pruning lines with exact integer tests.
// ---------------------------------------------------------------------------
//
//  Channel   Signals                                   Handshake
//  -------   ---------------------------------------   -----------------------
//  command   cmd, slope, intercept, query_x            start & !busy
//  result    best_value, status, line_count            done, one cycle, no hold
//  config    cfg_we, maximize_mode_in                  cfg_we, immediate
//
// A query scans the held lines one by one (memory read, one 32x32
// multiply, add and compare). An add scans for the insertion point, then
// runs each three-line test (one setup step, three memory reads, a 33x33
// multiply per side and a compare) and shifts the memory one entry at a
// time. Reset clears the count and the mode; the line memory is never
// cleared, as only entries below the count are read.
// busy is high from the accepting edge until the edge that raises done, so
// a new transaction can be accepted while done is high; the receiver
// cannot stall results.
//
// An add works in place. The new line's position p is found first. An
// equal slope either ends the add or overwrites entry p. If the add goes on, the new
// line is tested against its neighbors; a line that is useless is dropped
// with no change. Lines left of p and then right of p are pruned by
// testing and closing the gap. The count only exceeds MAX_LINES when the
// store is full, the line is new and nothing is pruned, and that add is
// then rejected before any write, so the store stays as it was.
// The new line is kept in registers and written last; neighbors are
// fetched by address, skipping over the virtual slot of the new line.

module dynamic_line_envelope_query_unit
	import dleq_pkg::*;
#(
	parameter int MAX_LINES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic signed [31:0] slope,
	input  logic signed [31:0] intercept,
	input  logic signed [31:0] query_x,
	input  logic               cfg_we,
	input  logic               maximize_mode_in,
	output logic               done,
	output logic signed [63:0] best_value,
	output logic [1:0]         status,
	output logic [6:0]         line_count
);

	localparam int AW = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
	localparam int CW = $clog2(MAX_LINES + 2);

	// Line memory: slope in the upper half, intercept in the lower half.
	logic [63:0] mem [MAX_LINES];
	logic [AW-1:0] rd_addr, wr_addr;
	logic          rd_en, wr_en;
	logic [63:0]   rd_data_q, wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	state_t state_q;
	test_t  test_q;
	logic   mode_q;
	logic [CW-1:0] n_q;          // lines held in memory
	logic [CW-1:0] idx_q;        // scan index
	logic [CW-1:0] p_q;          // insertion position of the new line
	logic [CW-1:0] v_q;          // virtual index under test (middle line)
	logic [1:0]    ld_q;         // which of three lines is being loaded
	logic          repl_q;       // equal slope: the new line replaces entry p
	logic          cmd_q;
	logic signed [31:0] m_new_q, b_new_q, x_q;
	logic signed [31:0] m_l_q[3];
	logic signed [31:0] b_l_q[3];
	logic signed [63:0] best_q, prod_q;
	logic signed [65:0] pa_q, pc_q;
	logic          first_q;
	logic [CW-1:0] mv_q, mv_end_q;   // memory move cursor and end
	logic          mv_dir_q;         // 1: shift up, 0: shift down
	logic [1:0]    st_q;
	logic          useless_q;

	// Virtual envelope: held lines with the new line at p. A virtual index
	// maps to either the new line or a memory address.
	function automatic logic [CW-1:0] phys(input logic [CW-1:0] v, input logic [CW-1:0] p,
			input logic repl);
		logic [CW-1:0] r;
		r = v;
		if (!repl && (v > p)) begin
			r = v - CW'(1);
		end
		return r;
	endfunction

	logic [CW-1:0] nv;  // virtual count
	assign nv = repl_q ? n_q : n_q + CW'(1);

	logic [CW-1:0] ld_v;
	always_comb begin
		ld_v = v_q;
		case (ld_q)
			2'd0:    ld_v = v_q - CW'(1);
			2'd2:    ld_v = v_q + CW'(1);
			default: ld_v = v_q;
		endcase
	end

	logic [CW-1:0] ld_phys, mv_src;
	assign ld_phys = phys(ld_v, p_q, repl_q);
	assign mv_src  = mv_dir_q ? (mv_q - CW'(1)) : (mv_q + CW'(1));

	// Three-line test operands, 33 bits each.
	logic signed [32:0] dA, dB, dC, dD;
	always_comb begin
		if (mode_q) begin
			dA = 33'(b_l_q[0]) - 33'(b_l_q[2]);
			dB = 33'(m_l_q[1]) - 33'(m_l_q[0]);
			dC = 33'(b_l_q[0]) - 33'(b_l_q[1]);
			dD = 33'(m_l_q[2]) - 33'(m_l_q[0]);
		end else begin
			dA = 33'(b_l_q[0]) - 33'(b_l_q[2]);
			dB = 33'(m_l_q[2]) - 33'(m_l_q[1]);
			dC = 33'(b_l_q[1]) - 33'(b_l_q[2]);
			dD = 33'(m_l_q[2]) - 33'(m_l_q[0]);
		end
	end

	logic signed [31:0] rd_m, rd_b;
	assign rd_m = rd_data_q[63:32];
	assign rd_b = rd_data_q[31:0];

	logic signed [63:0] qval;
	assign qval = prod_q + 64'(rd_b);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {m_new_q, b_new_q};
		unique case (state_q)
			S_QRD, S_FIND: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			S_LOAD: begin
				rd_en   = 1'b1;
				rd_addr = ld_phys[AW-1:0];
			end
			S_MOVE: begin
				rd_en   = 1'b1;
				rd_addr = mv_src[AW-1:0];
			end
			S_MWR: begin
				wr_en   = 1'b1;
				wr_addr = mv_q[AW-1:0];
				wr_data = rd_data_q;
			end
			S_DONE: begin
				wr_en   = (st_q == ST_OK) && (cmd_q == CMD_ADD) && !useless_q;
				wr_addr = p_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= 1'b0;
			n_q     <= '0;
			done    <= 1'b0;
			test_q  <= T_NEW;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				mode_q <= maximize_mode_in;
				n_q    <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						m_new_q   <= slope;
						b_new_q   <= intercept;
						x_q       <= query_x;
						idx_q     <= '0;
						first_q   <= 1'b1;
						repl_q    <= 1'b0;
						useless_q <= 1'b0;
						st_q      <= ST_OK;
						best_q    <= '0;
						test_q    <= T_NEW;
						if (cmd == CMD_QUERY) begin
							if (n_q == '0) begin
								st_q  <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								state_q <= S_QRD;
							end
						end else begin
							state_q <= (n_q == '0) ? S_TEST : S_FIND;
							p_q     <= '0;
						end
					end
				end
				S_QRD: state_q <= S_QMUL;
				S_QMUL: begin
					prod_q  <= 64'(rd_m) * 64'(x_q);
					state_q <= S_QCMP;
				end
				S_QCMP: begin
					if (first_q || (mode_q ? (qval > best_q) : (qval < best_q))) begin
						best_q <= qval;
					end
					first_q <= 1'b0;
					idx_q   <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(1) == n_q) ? S_DONE : S_QRD;
				end
				S_FIND: state_q <= S_ARD;
				S_ARD: begin
					// Entry idx_q is in the read register.
					if (rd_m < m_new_q) begin
						idx_q   <= idx_q + CW'(1);
						p_q     <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == n_q) ? S_TEST : S_FIND;
					end else if (rd_m == m_new_q) begin
						p_q <= idx_q;
						if (mode_q ? (rd_b < b_new_q) : (b_new_q < rd_b)) begin
							repl_q  <= 1'b1;
							state_q <= S_TEST;
						end else begin
							useless_q <= 1'b1;
							state_q   <= S_DONE;
						end
					end else begin
						p_q     <= idx_q;
						state_q <= S_TEST;
					end
					test_q <= T_NEW;
				end
				S_TEST: begin
					// Choose the next three-line test or finish the add.
					ld_q <= 2'd0;
					unique case (test_q)
						T_NEW: begin
							if (p_q > '0 && p_q + CW'(1) < nv) begin
								v_q <= p_q;
								state_q <= S_LOAD;
							end else begin
								test_q <= T_LEFT;
							end
						end
						T_LEFT: begin
							if (p_q >= CW'(2)) begin
								v_q <= p_q - CW'(1);
								state_q <= S_LOAD;
							end else begin
								test_q <= T_RIGHT;
							end
						end
						default: begin
							if (p_q + CW'(2) < nv) begin
								v_q <= p_q + CW'(1);
								state_q <= S_LOAD;
							end else if (nv > CW'(MAX_LINES)) begin
								st_q    <= ST_FULL;
								state_q <= S_DONE;
							end else if (!repl_q && p_q < n_q) begin
								// Open the slot at p by shifting up.
								mv_dir_q <= 1'b1;
								mv_q     <= n_q;
								mv_end_q <= p_q;
								state_q  <= S_MOVE;
							end else begin
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_LOAD: begin
					// Address issued this cycle; the data is captured in TMUL.
					state_q <= S_TMUL;
				end
				S_TMUL: begin
					if (ld_v == p_q) begin
						m_l_q[ld_q] <= m_new_q;
						b_l_q[ld_q] <= b_new_q;
					end else begin
						m_l_q[ld_q] <= rd_m;
						b_l_q[ld_q] <= rd_b;
					end
					if (ld_q == 2'd2) begin
						state_q <= S_TCMP;
						ld_q    <= 2'd3;
					end else begin
						ld_q    <= ld_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_TCMP: begin
					if (ld_q == 2'd3) begin
						pa_q <= 66'(dA) * 66'(dB);
						pc_q <= 66'(dC) * 66'(dD);
						ld_q <= 2'd0;
					end else if (pa_q <= pc_q) begin
						unique case (test_q)
							T_NEW: begin
								useless_q <= 1'b1;
								state_q   <= S_DONE;
							end
							T_LEFT: begin
								// Drop entry p-1: shift memory down from p.
								mv_dir_q <= 1'b0;
								mv_q     <= p_q - CW'(1);
								mv_end_q <= n_q - CW'(1);
								p_q      <= p_q - CW'(1);
								n_q      <= n_q - CW'(1);
								state_q  <= (p_q == n_q || (repl_q && p_q == n_q - CW'(1)))
									? S_TEST : S_MOVE;
							end
							default: begin
								// Drop the line at virtual p+1.
								mv_dir_q <= 1'b0;
								mv_q     <= phys(p_q + CW'(1), p_q, repl_q);
								mv_end_q <= n_q - CW'(1);
								n_q      <= n_q - CW'(1);
								state_q  <= (phys(p_q + CW'(1), p_q, repl_q) == n_q - CW'(1))
									? S_TEST : S_MOVE;
							end
						endcase
					end else begin
						unique case (test_q)
							T_NEW: begin
								test_q  <= T_LEFT;
								state_q <= S_TEST;
							end
							T_LEFT: begin
								test_q  <= T_RIGHT;
								state_q <= S_TEST;
							end
							default: begin
								// Right neighbor stays: finish via the full check.
								if (nv > CW'(MAX_LINES)) begin
									st_q    <= ST_FULL;
									state_q <= S_DONE;
								end else if (!repl_q && p_q < n_q) begin
									mv_dir_q <= 1'b1;
									mv_q     <= n_q;
									mv_end_q <= p_q;
									state_q  <= S_MOVE;
								end else begin
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_MOVE: state_q <= S_MWR;
				S_MWR: begin
					if (mv_dir_q) begin
						mv_q <= mv_q - CW'(1);
						if (mv_q - CW'(1) == mv_end_q) begin
							n_q     <= n_q + CW'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_MOVE;
						end
					end else begin
						mv_q <= mv_q + CW'(1);
						state_q <= (mv_q + CW'(1) == mv_end_q) ? S_TEST : S_MOVE;
					end
				end
				S_DONE: begin
					if (cmd_q == CMD_ADD && st_q == ST_OK && !useless_q && repl_q == 1'b0 &&
							p_q == n_q) begin
						n_q <= n_q + CW'(1);
					end
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result registers, loaded as the transaction completes.
	logic [CW-1:0] n_after;
	assign n_after = (cmd_q == CMD_ADD && st_q == ST_OK && !useless_q && !repl_q &&
		p_q == n_q) ? n_q + CW'(1) : n_q;

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			best_value <= (cmd_q == CMD_QUERY && st_q == ST_OK) ? best_q : '0;
			status     <= st_q;
			line_count <= 7'(n_after);
		end
	end

endmodule
